@@ hdl/pemx_pkg.sv @@
package pemx_pkg;

	localparam int WIN_DEPTH = 27;
	localparam int OPEN_LEN  = 27;
	localparam int CLOSE_LEN = 25;
	localparam int FILL_W    = 5;

	localparam logic [OPEN_LEN*8-1:0]  OPEN_MARK  = "-----BEGIN CERTIFICATE-----";
	localparam logic [CLOSE_LEN*8-1:0] CLOSE_MARK = "-----END CERTIFICATE-----";

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD     = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_UNTERM  = 2'd3
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		status_t    status;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} digit_t;

	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t d;
		d.valid = 1'b1;
		d.value = 6'd0;
		if (c >= "A" && c <= "Z") begin
			d.value = 6'(c - 8'h41);
		end else if (c >= "a" && c <= "z") begin
			d.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			d.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == "+") begin
			d.value = 6'd62;
		end else if (c == "/") begin
			d.value = 6'd63;
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

endpackage

@@ hdl/pemx_queue.sv @@
module pemx_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_cnt,
	input  pemx_pkg::res_t  push_item [2],
	input  logic            pop,
	output pemx_pkg::res_t  head,
	output logic            head_valid,
	output logic            room
);
	import pemx_pkg::*;

	res_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   cnt_q;
	logic              pop_fire;
	logic [Q_AW-1:0]   wr_ptr_p1;

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign room       = (cnt_q <= Q_CW'(Q_DEPTH - 2));
	assign pop_fire   = pop & head_valid;
	assign wr_ptr_p1  = wr_ptr_q + Q_AW'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_item[0];
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_item[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_cnt);
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			cnt_q <= cnt_q + Q_CW'(push_cnt) - Q_CW'(pop_fire);
		end
	end

endmodule

@@ hdl/pem_certificate_base64_extractor_core.sv @@
// Results: each result enters the four-entry result queue and leaves from its head.
// Throughput: one item per cycle while each item yields at most one result and the
// master side takes each result; an item yielding a data byte and a status pushes
// two entries, and the queue stalls input when fewer than two entries are free.
// Reset: arst_n clears the body state, decoder and queue at once; no clearing pass.
module pem_certificate_base64_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte[7:0]
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // data_byte[7:0], status[9:8], zero[15:10]
	output logic        m_tuser,   // kind
	output logic        m_tlast    // last_of_run
);
	import pemx_pkg::*;

	logic [WIN_DEPTH*8-1:0] win_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   inside_q;
	logic [5:0]             rem_q;
	logic [2:0]             rembits_q;
	logic                   pad_q;
	logic                   bad_q;
	logic                   any_q;

	logic                   acc;
	logic [WIN_DEPTH*8-1:0] win_n;
	logic [FILL_W-1:0]      cap;
	logic [FILL_W-1:0]      fill_inc;
	logic                   open_hit;
	logic                   close_hit;
	logic [7:0]             c;
	digit_t                 dv;
	logic                   is_ws;
	logic                   is_pad;
	logic                   step;
	logic                   take;
	logic                   emit;
	logic [11:0]            acc12;
	logic [3:0]             nbits;
	logic [2:0]             nb;
	logic [11:0]            shifted;
	logic [11:0]            keep_mask;
	logic [5:0]             rem_d;
	logic [2:0]             rembits_d;
	logic                   pad_d;
	logic                   bad_d;
	logic                   any_d;
	logic                   inside_after;
	logic                   stat_v;
	status_t                stat_code;
	res_t                   data_item;
	res_t                   stat_item;
	res_t                   push_item [2];
	logic [1:0]             push_cnt;
	res_t                   head;
	logic                   room;

	assign s_tready = room;
	assign acc      = s_tvalid & s_tready;

	assign win_n    = {win_q[WIN_DEPTH*8-9:0], s_tdata};
	assign cap      = inside_q ? FILL_W'(CLOSE_LEN) : FILL_W'(OPEN_LEN);
	assign fill_inc = (fill_q < cap) ? fill_q + FILL_W'(1) : cap;

	assign open_hit  = !inside_q && (fill_inc >= FILL_W'(OPEN_LEN)) &&
		(win_n[OPEN_LEN*8-1:0] == OPEN_MARK);
	assign close_hit = inside_q && (fill_inc >= FILL_W'(CLOSE_LEN)) &&
		(win_n[CLOSE_LEN*8-1:0] == CLOSE_MARK);

	assign c      = win_q[(CLOSE_LEN-1)*8 +: 8];
	assign dv     = digit_of(c);
	assign is_ws  = (c == 8'h0D) || (c == 8'h0A) || (c == 8'h20) || (c == 8'h09);
	assign is_pad = (c == "=");
	assign step   = inside_q && (fill_q >= FILL_W'(CLOSE_LEN)) && !bad_q && !pad_q;
	assign take   = step && dv.valid;
	assign pad_d  = pad_q | (step && is_pad);
	assign bad_d  = bad_q | (step && !is_ws && !is_pad && !dv.valid);

	assign acc12     = {rem_q, dv.value};
	assign nbits     = {1'b0, rembits_q} + 4'd6;
	assign emit      = take && (nbits >= 4'd8);
	assign nb        = 3'(nbits - 4'd8);
	assign shifted   = acc12 >> nb;
	assign keep_mask = (12'd1 << nb) - 12'd1;

	always_comb begin
		rem_d     = rem_q;
		rembits_d = rembits_q;
		if (emit) begin
			rem_d     = 6'(acc12 & keep_mask);
			rembits_d = nb;
		end else if (take) begin
			rem_d     = acc12[5:0];
			rembits_d = nbits[2:0];
		end
	end
	assign any_d = any_q | emit;

	assign inside_after = open_hit | (inside_q & !close_hit);
	assign stat_v       = close_hit | (s_tlast & inside_after);

	always_comb begin
		if (!close_hit) begin
			stat_code = ST_UNTERM;
		end else if (bad_d) begin
			stat_code = ST_BAD;
		end else if (any_d) begin
			stat_code = ST_OK;
		end else begin
			stat_code = ST_EMPTY;
		end
	end

	always_comb begin
		data_item.kind        = KIND_DATA;
		data_item.data_byte   = shifted[7:0];
		data_item.status      = ST_OK;
		data_item.last_of_run = !stat_v;
		stat_item.kind        = KIND_STATUS;
		stat_item.data_byte   = 8'd0;
		stat_item.status      = stat_code;
		stat_item.last_of_run = 1'b1;
		push_item[0]          = emit ? data_item : stat_item;
		push_item[1]          = stat_item;
		push_cnt              = acc ? (2'(emit) + 2'(stat_v)) : 2'd0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			win_q <= win_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			inside_q  <= 1'b0;
			rem_q     <= '0;
			rembits_q <= '0;
			pad_q     <= 1'b0;
			bad_q     <= 1'b0;
			any_q     <= 1'b0;
		end else if (acc) begin
			if (s_tlast || open_hit || close_hit) begin
				fill_q    <= '0;
				inside_q  <= open_hit && !s_tlast;
				rem_q     <= '0;
				rembits_q <= '0;
				pad_q     <= 1'b0;
				bad_q     <= 1'b0;
				any_q     <= 1'b0;
			end else begin
				fill_q    <= fill_inc;
				rem_q     <= rem_d;
				rembits_q <= rembits_d;
				pad_q     <= pad_d;
				bad_q     <= bad_d;
				any_q     <= any_d;
			end
		end
	end

	pemx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_item  (push_item),
		.pop        (m_tready),
		.head       (head),
		.head_valid (m_tvalid),
		.room       (room)
	);

	assign m_tdata = {6'd0, head.status, head.data_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last_of_run;

	a_fill_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> (fill_q <= FILL_W'(CLOSE_LEN)))
		else $error("body window fill out of range");

	a_rem_even: assert property (@(posedge clk) disable iff (!arst_n)
		!rembits_q[0] && (rembits_q <= 3'd6))
		else $error("odd or oversized bit remainder");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> (!inside_q && (fill_q == '0) && !pad_q && !bad_q))
		else $error("state not cleared after final item");

	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_STATUS)) |-> m_tlast)
		else $error("status item does not close its run");

endmodule
